// ----- src/mwcb_pkg.sv -----
// Package for the max-window chunk boundary block: field widths, cut causes,
// configuration register indexes and the length saturation helper.
// No dependencies.
package mwcb_pkg;

  localparam int unsigned LenW     = 21;
  localparam int unsigned ValW     = 64;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LaDepth  = 8;
  localparam int unsigned LaIdxW   = 3;
  localparam int unsigned CntW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned ModeW    = 2;

  localparam int unsigned LENGTH_LIMIT = 1048576;
  localparam int unsigned LenMax       = (1 << LenW) - 1;

  typedef logic [LenW-1:0]    len_t;
  typedef logic [ValW-1:0]    val_t;
  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [1:0]         cause_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [ModeW-1:0]   mode_t;

  localparam cause_t CauseValue  = 2'd0;
  localparam cause_t CauseMaxLen = 2'd1;
  localparam cause_t CauseEnd    = 2'd2;

  localparam cfg_idx_t CfgWindow   = 2'd0;
  localparam cfg_idx_t CfgMaxLen   = 2'd1;
  localparam cfg_idx_t CfgRollMode = 2'd2;

  localparam len_t LenFloor = len_t'(8);
  localparam len_t LenCap   = (LENGTH_LIMIT > LenMax) ? len_t'(LenMax)
                                                      : len_t'(LENGTH_LIMIT);

  localparam len_t  WindowReset  = len_t'(8192);
  localparam len_t  MaxLenReset  = len_t'(65536);
  localparam mode_t RollReset    = mode_t'(0);

  function automatic len_t sat_len(input len_t v);
    len_t r;
    if (v < LenFloor) begin
      r = LenFloor;
    end else if (v > LenCap) begin
      r = LenCap;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- src/max_window_chunk_boundary.sv -----
// Content-defined chunker: one byte per transaction, one chunk length per cut.
// Depends on mwcb_pkg.
//
//   channel | direction | handshake           | payload
//   in_     | sink      | in_valid / in_stall  | byte_value, end_of_stream
//   out_    | source    | out_valid / out_stall| chunk_length, cut_cause, last_result
//   cfg_    | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle when nothing stalls: a held byte is pushed into the 8-byte
// lookahead and the oldest position is decided in the same cycle. An end-of-stream
// byte is held until each pending position and the closing result are done; a
// byte after a lowered roll mode is held until each extra position is decided.
// Reset is synchronous, active low, loads default configuration and clears chunk
// state and valid flags. A stalled result stalls the decide logic and the input.
module max_window_chunk_boundary (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mwcb_pkg::byte_t    in_byte_value,
  input  logic               in_end_of_stream,
  output logic               out_valid,
  input  logic               out_stall,
  output mwcb_pkg::len_t     out_chunk_length,
  output mwcb_pkg::cause_t   out_cut_cause,
  output logic               out_last_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  mwcb_pkg::cfg_idx_t cfg_index,
  input  mwcb_pkg::len_t     cfg_data
);
  import mwcb_pkg::*;

  len_t   window_r;
  len_t   max_len_r;
  mode_t  roll_r;

  len_t   pos_r;
  val_t   max_r;
  byte_t  la_r [LaDepth];
  cnt_t   cnt_r;

  logic   it_valid_r;
  byte_t  it_byte_r;
  logic   it_eos_r;
  logic   it_pushed_r;

  logic   out_valid_r;
  len_t   out_len_r;
  cause_t out_cause_r;
  logic   out_last_r;

  cnt_t   w;
  len_t   win;
  len_t   lim;
  logic   out_free;
  logic   step;
  byte_t  la_work [LaDepth];
  cnt_t   cnt_work;
  cnt_t   cnt_nxt;
  logic   is_emit;
  logic   do_dec;
  val_t   value;
  logic   cut_len;
  logic   cut_val;
  logic   cut;
  len_t   pos_base;
  val_t   max_base;
  val_t   max_nxt;
  logic   item_done;
  logic   res_valid;
  cause_t res_cause;
  logic   res_last;
  logic   accept;

  assign w        = cnt_t'(1) << roll_r;
  assign win      = sat_len(window_r);
  assign lim      = sat_len(max_len_r);
  assign out_free = !out_valid_r || !out_stall;
  assign step     = it_valid_r && out_free;

  always_comb begin
    for (int i = 0; i < LaDepth; i++) begin
      la_work[i] = (!it_pushed_r && (cnt_r[LaIdxW-1:0] == LaIdxW'(i))) ? it_byte_r : la_r[i];
    end
    for (int k = 0; k < LaDepth; k++) begin
      value[k*ByteW +: ByteW] = (cnt_t'(k) < w) ? la_work[k] : '0;
    end
  end

  assign cnt_work  = it_pushed_r ? cnt_r : cnt_r + cnt_t'(1);
  assign is_emit   = it_pushed_r && it_eos_r && (cnt_r == '0);
  assign do_dec    = !is_emit && ((cnt_work >= w) || (it_eos_r && (cnt_work != '0)));

  assign cut_len   = pos_r >= lim;
  assign cut_val   = !cut_len && (pos_r >= win) && (value >= max_r);
  assign cut       = do_dec && (cut_len || cut_val);
  assign pos_base  = cut ? '0 : pos_r;
  assign max_base  = cut ? '0 : max_r;
  assign max_nxt   = ((pos_base < win) && (value > max_base)) ? value : max_base;
  assign cnt_nxt   = do_dec ? cnt_work - cnt_t'(1) : cnt_work;

  assign item_done = is_emit || (!it_eos_r && (cnt_nxt < w));
  assign res_valid = cut || is_emit;
  assign res_cause = is_emit ? CauseEnd : (cut_len ? CauseMaxLen : CauseValue);
  assign res_last  = is_emit || !it_eos_r;

  assign in_stall  = it_valid_r && !(step && item_done);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_chunk_length = out_len_r;
  assign out_cut_cause    = out_cause_r;
  assign out_last_result  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WindowReset;
      max_len_r   <= MaxLenReset;
      roll_r      <= RollReset;
      pos_r       <= '0;
      max_r       <= '0;
      cnt_r       <= '0;
      for (int i = 0; i < LaDepth; i++) begin
        la_r[i] <= '0;
      end
      it_valid_r  <= 1'b0;
      it_pushed_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgWindow:   window_r  <= cfg_data;
          CfgMaxLen:   max_len_r <= cfg_data;
          CfgRollMode: roll_r    <= cfg_data[ModeW-1:0];
          default:     ;
        endcase
      end

      if (step) begin
        if (is_emit) begin
          pos_r <= '0;
          max_r <= '0;
          cnt_r <= '0;
          for (int i = 0; i < LaDepth; i++) begin
            la_r[i] <= '0;
          end
        end else if (do_dec) begin
          pos_r <= pos_base + len_t'(1);
          max_r <= max_nxt;
          cnt_r <= cnt_nxt;
          for (int i = 0; i < LaDepth - 1; i++) begin
            la_r[i] <= la_work[i+1];
          end
          la_r[LaDepth-1] <= '0;
        end else begin
          cnt_r <= cnt_work;
          for (int i = 0; i < LaDepth; i++) begin
            la_r[i] <= la_work[i];
          end
        end
      end

      if (accept) begin
        it_valid_r  <= 1'b1;
        it_byte_r   <= in_byte_value;
        it_eos_r    <= in_end_of_stream;
        it_pushed_r <= 1'b0;
      end else if (step) begin
        it_pushed_r <= 1'b1;
        if (item_done) begin
          it_valid_r <= 1'b0;
        end
      end

      if (step && res_valid) begin
        out_valid_r <= 1'b1;
        out_len_r   <= pos_r;
        out_cause_r <= res_cause;
        out_last_r  <= res_last;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
